### design/ufd_pkg.sv
// Shared types, character constants and the hex nibble function of the form decoder.
`timescale 1ns / 1ps
`default_nettype none

package ufd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CASE_MASK  = 8'hDF;
  localparam logic [7:0] NIB_OFFSET = 8'd10;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HIGH = 2'd2;

  typedef struct packed {
    logic       part_is_value;
    logic [1:0] escape_phase;
    logic [7:0] high_char;
  } ufd_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_value_part;
    logic       end_of_name;
    logic       end_of_pair;
    logic       bad_escape;
  } ufd_result_t;

  // Hex digit value as the decoder defines it; non-hex characters give
  // whatever the wrapped arithmetic produces.
  function automatic logic [7:0] nibble_of(input logic [7:0] ch);
    logic [7:0] v;
    if (ch >= CH_UPPER_A) begin
      v = (ch & CASE_MASK) - CH_UPPER_A + NIB_OFFSET;
    end else begin
      v = ch - CH_ZERO;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### design/url_form_field_decoder_core.sv
// Top level of the form body decoder: input register, decode step, result register.
//
// The decoder takes one raw byte of an application/x-www-form-urlencoded body
// per transaction on the input channel (in_valid/in_ready, with in_byte and
// is_last) and returns decoded bytes and pair delimiter marks on the output
// channel (out_valid/out_ready). A byte that produces nothing visible, such as
// a '%' opening an escape or a NUL, yields no output transaction.
// A byte accepted on the input channel is held in the input register, decoded
// there and shown from the result register. One byte is accepted every cycle
// while the receiver keeps up; the split state (name or value part, escape
// phase, held high character) is eleven flip-flops updated as each byte
// leaves the input register.
// When the receiver stalls, the result register holds its transaction and the
// input register holds one more byte; in_ready then drops until out_ready
// returns. A synchronous reset empties both registers and returns the decoder
// to the name part with no escape pending; in_ready is low while rst is high.
`timescale 1ns / 1ps
`default_nettype none

module url_form_field_decoder_core
  import ufd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       is_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            in_value_part,
  output logic            end_of_name,
  output logic            end_of_pair,
  output logic            bad_escape
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_fire;
  ufd_state_t  state;
  ufd_state_t  state_next;
  ufd_result_t step_result;
  logic        step_has_result;
  ufd_result_t res;

  ufd_step u_step (
    .ch         (s1_byte),
    .last       (s1_last),
    .state      (state),
    .state_next (state_next),
    .result     (step_result),
    .has_result (step_has_result)
  );

  // The held byte retires once the result register can take its result.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || s1_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{part_is_value: 1'b0, escape_phase: ESC_IDLE, high_char: 8'h00};
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= step_has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && step_has_result) begin
      res <= step_result;
    end
  end

  assign out_byte      = res.out_byte;
  assign byte_valid    = res.byte_valid;
  assign in_value_part = res.in_value_part;
  assign end_of_name   = res.end_of_name;
  assign end_of_pair   = res.end_of_pair;
  assign bad_escape    = res.bad_escape;

  // A shown transaction always carries a byte or a mark.
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid || end_of_name || end_of_pair || bad_escape))
    else $error("empty result transaction");

  // Dropped or non-data results carry a zero byte.
  a_zero_when_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (out_byte == CH_NUL))
    else $error("out_byte nonzero without byte_valid");

  // A name can only be closed while in the name part.
  a_eon_in_name: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_name) |-> !in_value_part)
    else $error("end_of_name reported from value part");

  // The end of the body leaves the decoder at the start of a fresh pair.
  a_last_resets_split: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (!state.part_is_value && state.escape_phase == ESC_IDLE))
    else $error("split state not cleared after last byte");

  // The unused escape phase code is never stored.
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    (state.escape_phase == ESC_IDLE || state.escape_phase == ESC_PCT ||
     state.escape_phase == ESC_HIGH))
    else $error("illegal escape phase");

endmodule

`default_nettype wire

### design/ufd_step.sv
// Per-byte decode logic: delimiter split, plus mapping, escape decoding and next state.
`timescale 1ns / 1ps
`default_nettype none

module ufd_step
  import ufd_pkg::*;
(
  input  wire logic [7:0]  ch,
  input  wire logic        last,
  input  wire ufd_state_t  state,
  output ufd_state_t       state_next,
  output ufd_result_t      result,
  output logic             has_result
);

  logic [1:0] phase;
  logic [7:0] c;
  logic [7:0] hi_nib;
  logic [7:0] lo_nib;
  logic [7:0] esc_byte;
  logic       valid;
  logic       eon;
  logic       eop;
  logic       bad;
  logic [7:0] dec;

  always_comb begin
    hi_nib   = nibble_of(state.high_char);
    c        = (ch == CH_PLUS) ? CH_SPACE : ch;
    lo_nib   = nibble_of(c);
    esc_byte = {hi_nib[3:0], 4'b0000} + lo_nib;
  end

  always_comb begin
    // The unused phase code behaves as no escape pending.
    phase = (state.escape_phase == ESC_PCT || state.escape_phase == ESC_HIGH) ?
            state.escape_phase : ESC_IDLE;
    state_next              = state;
    state_next.escape_phase = phase;
    valid = 1'b0;
    eon   = 1'b0;
    eop   = 1'b0;
    bad   = 1'b0;
    dec   = CH_NUL;

    if (ch == CH_AMP) begin
      eop = 1'b1;
    end else if (ch == CH_EQUALS && !state.part_is_value) begin
      eon = 1'b1;
      bad = (phase != ESC_IDLE);
      state_next.escape_phase  = ESC_IDLE;
      state_next.part_is_value = 1'b1;
    end else if (ch != CH_NUL) begin
      case (phase)
        ESC_IDLE: begin
          if (c == CH_PERCENT) begin
            state_next.escape_phase = ESC_PCT;
          end else begin
            dec   = c;
            valid = 1'b1;
          end
        end
        ESC_PCT: begin
          state_next.high_char    = c;
          state_next.escape_phase = ESC_HIGH;
        end
        default: begin
          dec   = esc_byte;
          valid = (esc_byte != CH_NUL);
          state_next.escape_phase = ESC_IDLE;
        end
      endcase
    end

    if (last) begin
      eop = 1'b1;
    end

    if (eop) begin
      if (state_next.escape_phase != ESC_IDLE) begin
        bad = 1'b1;
      end
      state_next.escape_phase  = ESC_IDLE;
      state_next.part_is_value = 1'b0;
    end

    if (!valid) begin
      dec = CH_NUL;
    end

    result.out_byte      = dec;
    result.byte_valid    = valid;
    result.in_value_part = state.part_is_value;
    result.end_of_name   = eon;
    result.end_of_pair   = eop;
    result.bad_escape    = bad;
    has_result           = valid | eon | eop | bad;
  end

endmodule

`default_nettype wire
